@@ sv/sfp_pkg.sv @@
`default_nettype none

package sfp_pkg;

    localparam int CH_W        = 8;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 3;
    localparam int OUT_VALUE_W = 20;

    localparam int SENSOR_COUNT = 6;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [KIND_W-1:0] KIND_SENSOR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AIR    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GPS    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_GAIN   = 2'd3;

    localparam logic [CH_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [CH_W-1:0] CH_S      = 8'h53;
    localparam logic [CH_W-1:0] CH_G      = 8'h47;
    localparam logic [CH_W-1:0] CH_K      = 8'h4B;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;

    // work handed from the parser to the emitter
    typedef enum logic [2:0] {
        OP_SENSOR      = 3'd0,
        OP_AIR         = 3'd1,
        OP_GPS         = 3'd2,
        OP_GPS_HEAD    = 3'd3,
        OP_GPS_HEAD_CH = 3'd4,
        OP_GAINS       = 3'd5
    } t_op;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_TYPE     = 10'b00_0000_0010,
        ST_S_COMMA  = 10'b00_0000_0100,
        ST_S_FIELD  = 10'b00_0000_1000,
        ST_AIRSPEED = 10'b00_0001_0000,
        ST_G_FIRST  = 10'b00_0010_0000,
        ST_G_BODY   = 10'b00_0100_0000,
        ST_K_COMMA  = 10'b00_1000_0000,
        ST_K_FIELD  = 10'b01_0000_0000,
        ST_APPLY    = 10'b10_0000_0000
    } t_state;

endpackage

`default_nettype wire

@@ sv/sfp_front.sv @@
`default_nettype none

module sfp_front #(
    parameter int VALUE_BITS = 20,
    parameter int GAIN_COUNT = 6
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [sfp_pkg::CH_W-1:0]         i_ch,
    output sfp_pkg::t_op                          o_cmd_op,
    output logic                                  o_cmd_valid,
    output logic [sfp_pkg::IDX_W-1:0]             o_cmd_idx,
    output logic [GAIN_COUNT*VALUE_BITS-1:0]      o_cmd_vals
);
    import sfp_pkg::*;

    localparam int SLOT_W = (GAIN_COUNT > 1) ? $clog2(GAIN_COUNT) : 1;
    localparam int WIDE_W = VALUE_BITS + 4;

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_acc, n_acc;
    logic [IDX_W-1:0]        r_slot, n_slot;
    logic [VALUE_BITS-1:0]   r_gain [GAIN_COUNT];
    logic                    gain_we;

    logic                    is_digit;
    logic [WIDE_W-1:0]       acc_wide;
    logic [VALUE_BITS-1:0]   acc_next_digit;
    logic [VALUE_BITS-1:0]   single_val;
    logic [IDX_W:0]          slot_inc;

    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign slot_inc = {1'b0, r_slot} + (IDX_W+1)'(1);

    // acc * 10 + digit, clamped to all ones
    always_comb begin
        acc_wide = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0} + WIDE_W'(i_ch[3:0]);
        if (acc_wide[WIDE_W-1:VALUE_BITS] != 4'd0) begin
            acc_next_digit = {VALUE_BITS{1'b1}};
        end else begin
            acc_next_digit = acc_wide[VALUE_BITS-1:0];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_slot      = r_slot;
        gain_we     = 1'b0;
        o_cmd_valid = 1'b0;
        o_cmd_op    = OP_GPS;
        o_cmd_idx   = '0;
        single_val  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ch == CH_DOLLAR) n_state = ST_TYPE;
            end
            ST_TYPE: begin
                priority if (i_ch == CH_S) begin
                    n_state = ST_S_COMMA;
                end else if (i_ch == CH_G) begin
                    n_state = ST_G_FIRST;
                end else if (i_ch == CH_K) begin
                    n_state = ST_K_COMMA;
                end else begin
                    n_state = ST_IDLE;
                    n_acc   = '0;
                end
            end
            ST_S_COMMA, ST_K_COMMA: begin
                if (i_ch == CH_COMMA) begin
                    n_state = (r_state == ST_S_COMMA) ? ST_S_FIELD : ST_K_FIELD;
                    n_slot  = '0;
                end else begin
                    n_state = ST_IDLE;
                    n_acc   = '0;
                end
            end
            ST_S_FIELD: begin
                priority if (i_ch == CH_COMMA) begin
                    o_cmd_valid = 1'b1;
                    o_cmd_op    = OP_SENSOR;
                    o_cmd_idx   = r_slot;
                    single_val  = r_acc;
                    n_acc       = '0;
                    if (r_slot == IDX_W'(SENSOR_COUNT-1)) begin
                        n_state = ST_AIRSPEED;
                    end else begin
                        n_slot = slot_inc[IDX_W-1:0];
                    end
                end else if (is_digit) begin
                    n_acc = acc_next_digit;
                end else if (i_ch != CH_SPACE) begin
                    n_state = ST_IDLE;
                    n_acc   = '0;
                end else begin
                    // drop spaces inside a field
                end
            end
            ST_AIRSPEED: begin
                priority if (i_ch == CH_CR) begin
                    o_cmd_valid = 1'b1;
                    o_cmd_op    = OP_AIR;
                    single_val  = r_acc;
                    n_state     = ST_IDLE;
                    n_acc       = '0;
                end else if (is_digit) begin
                    n_acc = acc_next_digit;
                end else if (i_ch != CH_SPACE) begin
                    n_state = ST_IDLE;
                    n_acc   = '0;
                end else begin
                    // drop spaces inside a field
                end
            end
            ST_G_FIRST: begin
                o_cmd_valid = 1'b1;
                single_val  = VALUE_BITS'(i_ch);
                if (i_ch == CH_DOLLAR) begin
                    o_cmd_op = OP_GPS_HEAD;
                    n_state  = ST_TYPE;
                end else begin
                    o_cmd_op = OP_GPS_HEAD_CH;
                    n_state  = ST_G_BODY;
                end
            end
            ST_G_BODY: begin
                if (i_ch == CH_DOLLAR) begin
                    n_state = ST_TYPE;
                end else begin
                    o_cmd_valid = 1'b1;
                    o_cmd_op    = OP_GPS;
                    single_val  = VALUE_BITS'(i_ch);
                end
            end
            ST_K_FIELD: begin
                priority if (i_ch == CH_COMMA || i_ch == CH_CR || i_ch == CH_LF) begin
                    gain_we = 1'b1;
                    n_acc   = '0;
                    if (i_ch == CH_COMMA && slot_inc < (IDX_W+1)'(GAIN_COUNT)) begin
                        n_slot = slot_inc[IDX_W-1:0];
                    end else begin
                        n_state = ST_APPLY;
                    end
                end else if (is_digit) begin
                    n_acc = acc_next_digit;
                end else if (i_ch != CH_SPACE) begin
                    n_state = ST_IDLE;
                    n_acc   = '0;
                end else begin
                    // drop spaces inside a field
                end
            end
            ST_APPLY: begin
                // consume this character whatever it is and emit the stored run
                o_cmd_valid = 1'b1;
                o_cmd_op    = OP_GAINS;
                n_state     = ST_IDLE;
                n_acc       = '0;
            end
            default: begin
                n_state = ST_IDLE;
                n_acc   = '0;
            end
        endcase
    end

    always_comb begin
        o_cmd_vals = '0;
        if (o_cmd_op == OP_GAINS) begin
            for (int i = 0; i < GAIN_COUNT; i++) begin
                o_cmd_vals[i*VALUE_BITS +: VALUE_BITS] = r_gain[i];
            end
        end else begin
            o_cmd_vals[VALUE_BITS-1:0] = single_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_acc   <= '0;
            r_slot  <= '0;
            for (int i = 0; i < GAIN_COUNT; i++) begin
                r_gain[i] <= '0;
            end
        end else if (i_valid) begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_slot  <= n_slot;
            if (gain_we) begin
                r_gain[r_slot[SLOT_W-1:0]] <= r_acc;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/sfp_queue.sv @@
`default_nettype none

module sfp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH-1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH-1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/sfp_back.sv @@
`default_nettype none

module sfp_back #(
    parameter int VALUE_BITS = 20,
    parameter int GAIN_COUNT = 6
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_head_valid,
    input  wire sfp_pkg::t_op                     i_head_op,
    input  wire logic [sfp_pkg::IDX_W-1:0]        i_head_idx,
    input  wire logic [GAIN_COUNT*VALUE_BITS-1:0] i_head_vals,
    output logic                                  o_head_done,
    input  wire logic                             i_pop,
    output logic                                  o_empty,
    output logic [sfp_pkg::KIND_W-1:0]            o_kind,
    output logic [sfp_pkg::IDX_W-1:0]             o_index,
    output logic [sfp_pkg::OUT_VALUE_W-1:0]       o_value,
    output logic                                  o_last
);
    import sfp_pkg::*;

    localparam int SLOT_W = (GAIN_COUNT > 1) ? $clog2(GAIN_COUNT) : 1;

    logic                      r_out_valid;
    logic [KIND_W-1:0]         r_kind;
    logic [IDX_W-1:0]          r_index;
    logic [OUT_VALUE_W-1:0]    r_value;
    logic                      r_last;
    logic [IDX_W-1:0]          r_step;

    logic                      load;
    logic                      last_step;
    logic [IDX_W-1:0]          final_step;
    logic [KIND_W-1:0]         n_kind;
    logic [IDX_W-1:0]          n_index;
    logic [VALUE_BITS-1:0]     sel_val;
    logic [VALUE_BITS-1:0]     gain_val;
    logic [31:0]               val_wide;

    assign load        = i_head_valid && (!r_out_valid || i_pop);
    assign last_step   = (r_step == final_step);
    assign o_head_done = load && last_step;

    assign gain_val = i_head_vals[r_step[SLOT_W-1:0]*VALUE_BITS +: VALUE_BITS];

    always_comb begin
        final_step = '0;
        n_kind     = KIND_GPS;
        n_index    = '0;
        sel_val    = i_head_vals[VALUE_BITS-1:0];
        unique case (i_head_op)
            OP_SENSOR: begin
                n_kind  = KIND_SENSOR;
                n_index = i_head_idx;
            end
            OP_AIR: begin
                n_kind = KIND_AIR;
            end
            OP_GPS: begin
                n_kind = KIND_GPS;
            end
            OP_GPS_HEAD, OP_GPS_HEAD_CH: begin
                final_step = (i_head_op == OP_GPS_HEAD) ? IDX_W'(1) : IDX_W'(2);
                if (r_step == '0) begin
                    sel_val = VALUE_BITS'(CH_DOLLAR);
                end else if (r_step == IDX_W'(1)) begin
                    sel_val = VALUE_BITS'(CH_G);
                end
            end
            OP_GAINS: begin
                final_step = IDX_W'(GAIN_COUNT-1);
                n_kind     = KIND_GAIN;
                n_index    = r_step;
                sel_val    = gain_val;
            end
            default: begin
            end
        endcase
    end

    assign val_wide = 32'(sel_val);

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_index <= n_index;
            r_value <= val_wide[OUT_VALUE_W-1:0];
            r_last  <= last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_step      <= last_step ? '0 : r_step + IDX_W'(1);
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty = !r_out_valid;
    assign o_kind  = r_kind;
    assign o_index = r_index;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

`default_nettype wire

@@ sv/sentence_field_parser_top.sv @@
// Path: an accepted character's result passes through the queue entry and then the output register.
// Throughput: one character per cycle while full is low; results leave one per cycle while pop
// is held, so a gain run of GAIN_COUNT results holds the port and the four-entry queue absorbs it.
// full rises only when the queue between parser and emitter has no free entry.
// Reset: synchronous, active low; clears parser state, accumulator, gain store,
// queue pointers and the output valid flag.
`default_nettype none

module sentence_field_parser_top #(
    parameter int VALUE_BITS = 20,
    parameter int GAIN_COUNT = 6
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [sfp_pkg::CH_W-1:0]        i_ch,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [sfp_pkg::KIND_W-1:0]           o_kind,
    output logic [sfp_pkg::IDX_W-1:0]            o_index,
    output logic [sfp_pkg::OUT_VALUE_W-1:0]      o_value,
    output logic                                 o_last
);
    import sfp_pkg::*;

    localparam int VALS_W  = GAIN_COUNT * VALUE_BITS;
    localparam int OP_W    = $bits(t_op);
    localparam int ENTRY_W = OP_W + IDX_W + VALS_W;

    logic                in_ok;
    logic                cmd_valid;
    t_op                 cmd_op;
    logic [IDX_W-1:0]    cmd_idx;
    logic [VALS_W-1:0]   cmd_vals;
    logic [ENTRY_W-1:0]  q_head;
    logic                q_full, q_empty;
    logic                head_done;
    t_op                 head_op;

    assign in_ok = push && !q_full;
    assign full  = q_full;

    sfp_front #(
        .VALUE_BITS (VALUE_BITS),
        .GAIN_COUNT (GAIN_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_ok),
        .i_ch        (i_ch),
        .o_cmd_op    (cmd_op),
        .o_cmd_valid (cmd_valid),
        .o_cmd_idx   (cmd_idx),
        .o_cmd_vals  (cmd_vals)
    );

    sfp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_ok && cmd_valid),
        .i_data  ({cmd_op, cmd_idx, cmd_vals}),
        .i_pop   (head_done),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign head_op = t_op'(q_head[ENTRY_W-1 -: OP_W]);

    sfp_back #(
        .VALUE_BITS (VALUE_BITS),
        .GAIN_COUNT (GAIN_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head_op    (head_op),
        .i_head_idx   (q_head[VALS_W +: IDX_W]),
        .i_head_vals  (q_head[VALS_W-1:0]),
        .o_head_done  (head_done),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_kind       (o_kind),
        .o_index      (o_index),
        .o_value      (o_value),
        .o_last       (o_last)
    );

    a_gain_run_ends_on_top_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last && o_kind == KIND_GAIN) |-> (o_index == IDX_W'(GAIN_COUNT-1)))
        else $error("gain run ended on wrong slot");

    a_unslotted_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_AIR || o_kind == KIND_GPS)) |-> (o_index == '0))
        else $error("airspeed or GPS item carries a slot number");

    a_no_result_from_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_empty && empty) |=> empty)
        else $error("result appeared with no queued work");

endmodule

`default_nettype wire

@@ sim/tb_sentence_field_parser_top.sv @@
`default_nettype none

module tb_sentence_field_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfp_pkg::*;

    localparam int GAINS        = 6;
    localparam int VALUE_W      = 20;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 3000;
    localparam int PHASE1_START = 100;
    localparam int PHASE2_START = 190;
    localparam int ITEM_TOTAL   = 290;

    class uplink_scoreboard;
        typedef struct packed {
            logic [KIND_W-1:0]      kind;
            logic [IDX_W-1:0]       index;
            logic [OUT_VALUE_W-1:0] value;
            logic                   last;
        } t_field;

        localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

        t_state             pstate;
        int                 slot;
        logic [VALUE_W-1:0] acc;
        logic [VALUE_W-1:0] gains [GAINS];
        t_field             expected_fields [$];
        t_field             batch [$];
        int                 n_errors;

        function new();
            pstate   = ST_IDLE;
            slot     = 0;
            acc      = '0;
            n_errors = 0;
            foreach (gains[g]) gains[g] = '0;
        endfunction

        function void emit(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx,
                           logic [VALUE_W-1:0] val);
            t_field f;
            f.kind  = kind;
            f.index = idx;
            f.value = val;
            f.last  = 1'b0;
            batch.push_back(f);
        endfunction

        function void add_digit(logic [CH_W-1:0] c);
            longint unsigned t;
            t   = longint'(acc) * 10 + longint'(c - CH_ZERO);
            acc = (t > VALUE_MAX) ? VALUE_MAX : t[VALUE_W-1:0];
        endfunction

        function void abort_sentence();
            acc    = '0;
            pstate = ST_IDLE;
        endfunction

        // advance the parser by one accepted character and queue what it emits
        function void note_char(logic [CH_W-1:0] c);
            logic   is_digit;
            t_field f;
            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            batch.delete();
            case (pstate)
                ST_IDLE: begin
                    if (c == CH_DOLLAR) pstate = ST_TYPE;
                end
                ST_TYPE: begin
                    if (c == CH_S)      pstate = ST_S_COMMA;
                    else if (c == CH_G) pstate = ST_G_FIRST;
                    else if (c == CH_K) pstate = ST_K_COMMA;
                    else                abort_sentence();
                end
                ST_S_COMMA, ST_K_COMMA: begin
                    if (c == CH_COMMA) begin
                        pstate = (pstate == ST_S_COMMA) ? ST_S_FIELD : ST_K_FIELD;
                        slot   = 0;
                    end else begin
                        abort_sentence();
                    end
                end
                ST_S_FIELD: begin
                    if (c == CH_COMMA) begin
                        emit(KIND_SENSOR, IDX_W'(slot), acc);
                        acc  = '0;
                        slot = slot + 1;
                        if (slot == SENSOR_COUNT) pstate = ST_AIRSPEED;
                    end else if (is_digit) begin
                        add_digit(c);
                    end else if (c != CH_SPACE) begin
                        abort_sentence();
                    end
                end
                ST_AIRSPEED: begin
                    if (c == CH_CR) begin
                        emit(KIND_AIR, '0, acc);
                        abort_sentence();
                    end else if (is_digit) begin
                        add_digit(c);
                    end else if (c != CH_SPACE) begin
                        abort_sentence();
                    end
                end
                ST_G_FIRST, ST_G_BODY: begin
                    if (pstate == ST_G_FIRST) begin
                        emit(KIND_GPS, '0, VALUE_W'(CH_DOLLAR));
                        emit(KIND_GPS, '0, VALUE_W'(CH_G));
                        pstate = ST_G_BODY;
                    end
                    if (c == CH_DOLLAR) pstate = ST_TYPE;
                    else                emit(KIND_GPS, '0, VALUE_W'(c));
                end
                ST_K_FIELD: begin
                    if (c == CH_CR || c == CH_LF || c == CH_COMMA) begin
                        gains[slot] = acc;
                        acc         = '0;
                        if (c == CH_COMMA && slot + 1 < GAINS) slot = slot + 1;
                        else                                   pstate = ST_APPLY;
                    end else if (is_digit) begin
                        add_digit(c);
                    end else if (c != CH_SPACE) begin
                        abort_sentence();
                    end
                end
                ST_APPLY: begin
                    for (int g = 0; g < GAINS; g++) emit(KIND_GAIN, IDX_W'(g), gains[g]);
                    abort_sentence();
                end
                default: abort_sentence();
            endcase
            if (batch.size() > 0) begin
                f      = batch.pop_back();
                f.last = 1'b1;
                batch.push_back(f);
            end
            foreach (batch[k]) expected_fields.push_back(batch[k]);
        endfunction

        function void miss(string name, longint unsigned want, longint unsigned got);
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            n_errors++;
        endfunction

        function void check_field(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] index,
                                  logic [OUT_VALUE_W-1:0] value, logic last);
            t_field want;
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d index %0d",
                         $time, kind, index);
                $display("%0t: unexpected result value %0d last %0d", $time, value, last);
                n_errors++;
                return;
            end
            want = expected_fields.pop_front();
            if (kind !== want.kind)   miss("kind", want.kind, kind);
            if (index !== want.index) miss("index", want.index, index);
            if (value !== want.value) miss("value", want.value, value);
            if (last !== want.last)   miss("last", want.last, last);
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction
    endclass

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push    = 1'b0;
    logic                   pop     = 1'b0;
    logic [CH_W-1:0]        i_ch    = '0;
    logic                   full;
    logic                   empty;
    logic [KIND_W-1:0]      o_kind;
    logic [IDX_W-1:0]       o_index;
    logic [OUT_VALUE_W-1:0] o_value;
    logic                   o_last;

    uplink_scoreboard board;
    int   n_sent       = 0;
    int   phase        = 0;
    logic hold_req     = 1'b0;
    logic hold_done    = 1'b0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;

    sentence_field_parser_top #(
        .VALUE_BITS(VALUE_W),
        .GAIN_COUNT(GAINS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_ch   (i_ch),
        .empty  (empty),
        .pop    (pop),
        .o_kind (o_kind),
        .o_index(o_index),
        .o_value(o_value),
        .o_last (o_last)
    );

    always #6 i_clk = ~i_clk;

    // offer one character and hold it until the block takes it
    task automatic send_char(input logic [CH_W-1:0] c);
        phase <= (n_sent < PHASE1_START) ? 0 : (n_sent < PHASE2_START) ? 1 : 2;
        while ($urandom_range(0, 99) < ((phase == 0) ? 9 : (phase == 1) ? 72 : 0)) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_ch <= c;
        do @(posedge i_clk); while (full);
        board.note_char(c);
        n_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
    endtask

    task automatic send_number();
        int len;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 4);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) send_char(CH_SPACE);
            send_char(CH_ZERO + CH_W'($urandom_range(0, 9)));
        end
    endtask

    task automatic send_sensor_sentence();
        send_text("$S,");
        for (int f = 0; f <= SENSOR_COUNT; f++) begin
            send_number();
            if ($urandom_range(0, 24) == 0) send_char(CH_W'($urandom_range(0, 255)));
            send_char((f < SENSOR_COUNT) ? CH_COMMA : CH_CR);
        end
    endtask

    task automatic send_gain_sentence();
        int count;
        count = $urandom_range(1, GAINS);
        send_text("$K,");
        for (int g = 0; g < count; g++) begin
            send_number();
            if ($urandom_range(0, 24) == 0) send_char(CH_W'($urandom_range(0, 255)));
            if (g < count - 1) begin
                send_char(CH_COMMA);
            end else begin
                case ($urandom_range(0, 2))
                    0:       send_char((count == GAINS) ? CH_COMMA : CH_CR);
                    1:       send_char(CH_CR);
                    default: send_char(CH_LF);
                endcase
            end
        end
        // apply step takes any character
        send_char(CH_W'($urandom_range(0, 255)));
    endtask

    task automatic send_gps_sentence(input int len);
        send_text("$G");
        repeat (len) send_char(CH_W'($urandom_range(0, 255)));
    endtask

    // result side: pop at random, with one long hold to back up the queue
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) board.check_field(o_kind, o_index, o_value, o_last);
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                pop       <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= ((phase == 0) ? 72 : (phase == 1) ? 9 : 0));
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[sentence_field_parser_top] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        bit burst_sent;
        burst_sent = 1'b0;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle noise, saturation, spaces, empty field, GPS start and restart,
        // short gain run, unknown type, missing comma, bad character in a field
        send_char(8'h00);
        send_char(8'hFF);
        send_text("$S,9999999,1 2,,0,3,4,5");
        send_char(CH_CR);
        send_text("$G$Ga$K,7");
        send_char(CH_CR);
        send_text("x");
        send_text("$X$S;$K,8 z");

        while (n_sent < ITEM_TOTAL) begin
            if (n_sent >= PHASE2_START && !burst_sent) begin
                burst_sent = 1'b1;
                hold_req  <= 1'b1;
                send_gps_sentence(30);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_sensor_sentence();
                4, 5:       send_gain_sentence();
                6, 7:       send_gps_sentence($urandom_range(0, 12));
                8:          repeat ($urandom_range(1, 4)) send_char(CH_W'($urandom_range(0, 255)));
                default: begin
                    send_char(CH_DOLLAR);
                    send_char(CH_W'($urandom_range(0, 255)));
                end
            endcase
        end
        push <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (board.n_errors == 0) begin
            $display("[sentence_field_parser_top] OK");
        end else begin
            $display("[sentence_field_parser_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
